// File: rtl/dpdg_pkg.sv
// Package for the density peak decision graph block.
// Holds the sequencer state type and the configuration register indexes.
// No dependencies.
`default_nettype none

package dpdg_pkg;

  localparam int PC_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_RADIUS = 2'd1;

  localparam logic [PC_W-1:0] POINT_COUNT_RESET = 7'd64;
  localparam int CUTOFF_RESET = 128;

  typedef enum logic [2:0] {
    S_LOAD,
    S_DENS,
    S_GAP,
    S_PEAK,
    S_TAIL,
    S_EMIT
  } dpdg_state_t;

endpackage

`default_nettype wire

// File: rtl/density_peak_decision_graph.sv
// Density peak decision graph: loads a distance matrix and emits rho, delta and gamma per point.
// Depends on dpdg_pkg for the sequencer state type and the register indexes.
// The distance and density stores are inferred memories inside this module.
`default_nettype none

// The block takes the n x n distance matrix one entry per transfer, in row-major order,
// and is ready for a new entry in every cycle while loading. The transfer that completes
// the matrix starts the computation, during which input stalls: one pass over the matrix
// counts the densities, a gap state follows, and then each point reads its row to find
// its nearest denser point, passes a tail state and waits in the emit state on out_stall.
// The pace is set by the single read port of the distance memory, which feeds the density
// and peak logic one entry per cycle, so the whole matrix is read twice. No clearing
// pass is needed after reset; a new matrix may be loaded as soon as the last result of the
// previous one has been placed in the output register, even while it still waits there.
module density_peak_decision_graph #(
  parameter int MAX_POINTS = 64,
  parameter int DIST_WIDTH = 16
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       cfg_we,
  input  wire [dpdg_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  wire [DIST_WIDTH-1:0]                      cfg_data,
  input  wire                                       in_valid,
  output logic                                      in_stall,
  input  wire [DIST_WIDTH-1:0]                      in_pair_distance,
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output logic [$clog2(MAX_POINTS)-1:0]             out_point_index,
  output logic [$clog2(MAX_POINTS+1)-1:0]           out_local_density,
  output logic [DIST_WIDTH-1:0]                     out_dependent_distance,
  output logic                                      out_has_denser,
  output logic [$clog2(MAX_POINTS)-1:0]             out_denser_neighbor,
  output logic [DIST_WIDTH+$clog2(MAX_POINTS+1)-2:0] out_peak_score,
  output logic                                      out_last_result
);

  import dpdg_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DEPTH = MAX_POINTS * MAX_POINTS;
  localparam int AW = $clog2(DEPTH);
  localparam int LC_W = $clog2(DEPTH + 1);
  localparam int PS_W = DIST_WIDTH + CNT_W - 1;
  localparam int PR_W = DIST_WIDTH + CNT_W;

  dpdg_state_t state_r, state_nxt;

  logic [PC_W-1:0]       point_count_r;
  logic [DIST_WIDTH-1:0] cutoff_radius_r;

  logic [LC_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;

  logic             p_vld_r, p_peak_r, p_first_r, p_last_r;
  logic [IDX_W-1:0] p_col_r, p_row_r;

  logic [CNT_W-1:0]      cnt_r;
  logic [DIST_WIDTH-1:0] acc_max_r, acc_best_r;
  logic                  acc_found_r;
  logic [IDX_W-1:0]      acc_nb_r;

  logic                  out_valid_r;

  logic [DIST_WIDTH-1:0] dist_mem [DEPTH];
  logic [DIST_WIDTH-1:0] dist_q;
  logic [CNT_W-1:0]      dens_mem [MAX_POINTS];
  logic [CNT_W-1:0]      dens_a_q, dens_b_q;

  logic [CNT_W-1:0]      n_act, n_m1;
  logic [LC_W-1:0]       total, load_inc;
  logic                  load_done, in_accept, issue, last_col, last_row, emit_go;
  logic [CNT_W-1:0]      cnt_sum;
  logic                  found_in, cand, take;
  logic [DIST_WIDTH-1:0] max_in, sel_dist;
  logic [PR_W-1:0]       product;

  always_comb begin
    if (point_count_r == '0) begin
      n_act = CNT_W'(1);
    end else if (point_count_r > PC_W'(MAX_POINTS)) begin
      n_act = CNT_W'(MAX_POINTS);
    end else begin
      n_act = point_count_r[CNT_W-1:0];
    end
  end

  assign n_m1      = n_act - CNT_W'(1);
  assign total     = LC_W'(n_act) * LC_W'(n_act);
  assign load_inc  = load_cnt_r + LC_W'(1);
  assign load_done = load_inc >= total;
  assign in_accept = in_valid && !in_stall;
  assign issue     = (state_r == S_DENS) || (state_r == S_PEAK);
  assign last_col  = col_r == n_m1[IDX_W-1:0];
  assign last_row  = row_r == n_m1[IDX_W-1:0];
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign in_stall  = state_r != S_LOAD;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r   <= POINT_COUNT_RESET;
      cutoff_radius_r <= DIST_WIDTH'(CUTOFF_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT:   point_count_r   <= cfg_data[PC_W-1:0];
        CFG_CUTOFF_RADIUS: cutoff_radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && load_done) state_nxt = S_DENS;
      end
      S_DENS: begin
        if (last_col && last_row) state_nxt = S_GAP;
      end
      S_GAP:  state_nxt = S_PEAK;
      S_PEAK: begin
        if (last_col) state_nxt = S_TAIL;
      end
      S_TAIL: state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_go) state_nxt = last_row ? S_LOAD : S_PEAK;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    addr_nxt     = addr_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          load_cnt_nxt = load_done ? '0 : load_inc;
          addr_nxt     = '0;
          row_nxt      = '0;
          col_nxt      = '0;
        end
      end
      S_DENS: begin
        addr_nxt = addr_r + AW'(1);
        col_nxt  = last_col ? '0 : col_r + IDX_W'(1);
        if (last_col) row_nxt = last_row ? '0 : row_r + IDX_W'(1);
      end
      S_GAP: begin
        addr_nxt = '0;
        row_nxt  = '0;
        col_nxt  = '0;
      end
      S_PEAK: begin
        addr_nxt = addr_r + AW'(1);
        col_nxt  = last_col ? '0 : col_r + IDX_W'(1);
      end
      S_EMIT: begin
        if (emit_go && !last_row) row_nxt = row_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      p_vld_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      p_vld_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    p_peak_r  <= state_r == S_PEAK;
    p_first_r <= col_r == '0;
    p_last_r  <= last_col;
    p_col_r   <= col_r;
    p_row_r   <= row_r;
  end

  always_ff @(posedge clk) begin
    if (in_accept) dist_mem[load_cnt_r[AW-1:0]] <= in_pair_distance;
    dist_q <= dist_mem[addr_r];
  end

  assign cnt_sum = (p_first_r ? '0 : cnt_r)
                 + CNT_W'(dist_q <= cutoff_radius_r);

  always_ff @(posedge clk) begin
    if (p_vld_r && !p_peak_r && p_last_r) dens_mem[p_row_r] <= cnt_sum;
    dens_a_q <= dens_mem[col_r];
    dens_b_q <= dens_mem[row_r];
  end

  assign found_in = p_first_r ? 1'b0 : acc_found_r;
  assign max_in   = p_first_r ? '0 : acc_max_r;
  assign cand     = dens_a_q > dens_b_q;
  assign take     = cand && (!found_in || dist_q < acc_best_r);

  always_ff @(posedge clk) begin
    if (p_vld_r && !p_peak_r) cnt_r <= cnt_sum;
    if (p_vld_r && p_peak_r) begin
      acc_max_r   <= (dist_q > max_in) ? dist_q : max_in;
      acc_found_r <= found_in || cand;
      if (take) begin
        acc_best_r <= dist_q;
        acc_nb_r   <= p_col_r;
      end
    end
  end

  assign sel_dist = acc_found_r ? acc_best_r : acc_max_r;
  assign product  = PR_W'(sel_dist) * PR_W'(dens_b_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_point_index        <= row_r;
      out_local_density      <= dens_b_q;
      out_dependent_distance <= sel_dist;
      out_has_denser         <= acc_found_r;
      out_denser_neighbor    <= acc_found_r ? acc_nb_r : '0;
      out_peak_score         <= product[PS_W-1:0];
      out_last_result        <= last_row;
    end
  end

  a_stage_idle_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !p_vld_r || !p_peak_r)
    else $error("peak stage active while loading");

  a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && last_row |=> state_r == S_LOAD && load_cnt_r == '0 && out_last_result)
    else $error("final result did not return the block to loading");

  a_count_clear_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> load_cnt_r == '0)
    else $error("load count not cleared during computation");

  a_denser_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && acc_found_r |=> out_local_density != CNT_W'(MAX_POINTS))
    else $error("densest possible point reported a denser neighbour");

endmodule

`default_nettype wire

// File: dv/dpdg_decision_checker.sv
// Checker for the density peak decision graph: watches the configuration port and both
// channels, predicts each point's density, delta and gamma, and compares every result.
// Depends on dpdg_pkg for the register indexes and reset values.
module dpdg_decision_checker
  import dpdg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [15:0]          in_pair_distance,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [5:0]           out_point_index,
  input  logic [6:0]           out_local_density,
  input  logic [15:0]          out_dependent_distance,
  input  logic                 out_has_denser,
  input  logic [5:0]           out_denser_neighbor,
  input  logic [21:0]          out_peak_score,
  input  logic                 out_last_result,
  output int                   fail_count,
  output int                   pending_count,
  output int                   checked_count
);

  typedef struct packed {
    logic [5:0]  point;
    logic [6:0]  density;
    logic [15:0] delta;
    logic        has_denser;
    logic [5:0]  neighbour;
    logic [21:0] gamma;
    logic        last;
  } decision_t;

  logic [15:0] distance_mem [0:4095];
  logic [6:0]  density_mem [0:63];
  logic [6:0]  points_q;
  logic [15:0] radius_q;
  logic [11:0] loaded;
  decision_t   expected_decisions [$];
  int          mismatches = 0;
  int          compared = 0;

  function automatic int unsigned live_points();
    int unsigned n;
    n = 32'(points_q);
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  task automatic predict_decisions();
    int unsigned n;
    int unsigned count;
    logic        found;
    logic [15:0] best;
    logic [15:0] row_max;
    logic [15:0] d;
    logic [5:0]  near;
    logic [31:0] product;
    decision_t   r;
    n = live_points();
    for (int unsigned i = 0; i < n; i++) begin
      count = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (distance_mem[i * n + j] <= radius_q) count++;
      end
      density_mem[i] = count[6:0];
    end
    for (int unsigned i = 0; i < n; i++) begin
      found = 1'b0;
      best = '0;
      row_max = '0;
      near = '0;
      for (int unsigned j = 0; j < n; j++) begin
        d = distance_mem[i * n + j];
        if (d > row_max) row_max = d;
        if (density_mem[j] > density_mem[i] && (!found || d < best)) begin
          best = d;
          near = j[5:0];
          found = 1'b1;
        end
      end
      if (!found) begin
        best = row_max;
        near = '0;
      end
      product = 32'(best) * 32'(density_mem[i]);
      r.point = i[5:0];
      r.density = density_mem[i];
      r.delta = best;
      r.has_denser = found;
      r.neighbour = near;
      r.gamma = product[21:0];
      r.last = (i + 1 == n);
      expected_decisions = {expected_decisions, r};
    end
  endtask

  task automatic compare_field(input string field, input int unsigned point,
                               input logic [31:0] want_v, input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s of point %0d: expected %0d, got %0d", $time, field, point, want_v,
               got_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    decision_t want;
    if (!rst_n) begin
      points_q = POINT_COUNT_RESET;
      radius_q = 16'(CUTOFF_RESET);
      loaded = '0;
      expected_decisions.delete();
    end else begin
      if (in_valid && !in_stall) begin
        distance_mem[loaded] = in_pair_distance;
        loaded = loaded + 12'd1;
        if (loaded == 0 || int'(loaded) >= live_points() * live_points()) begin
          loaded = '0;
          predict_decisions();
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_POINT_COUNT) points_q = cfg_data[6:0];
        else if (cfg_index == CFG_CUTOFF_RADIUS) radius_q = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_decisions.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer for point %0d with no result expected", $time,
                   out_point_index);
        end else begin
          want = expected_decisions.pop_front();
          compare_field("point_index", 32'(want.point), 32'(want.point),
                        32'(out_point_index));
          compare_field("local_density", 32'(want.point), 32'(want.density),
                        32'(out_local_density));
          compare_field("dependent_distance", 32'(want.point), 32'(want.delta),
                        32'(out_dependent_distance));
          compare_field("has_denser", 32'(want.point), 32'(want.has_denser),
                        32'(out_has_denser));
          compare_field("denser_neighbor", 32'(want.point), 32'(want.neighbour),
                        32'(out_denser_neighbor));
          compare_field("peak_score", 32'(want.point), 32'(want.gamma),
                        32'(out_peak_score));
          compare_field("last_result", 32'(want.point), 32'(want.last),
                        32'(out_last_result));
          compared++;
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= expected_decisions.size();
    checked_count <= compared;
  end

endmodule

// File: dv/density_peak_decision_graph_tb.sv
// Testbench top for density_peak_decision_graph: drives the configuration port and the
// distance matrices, idles both channels and gives the verdict.
// Depends on dpdg_pkg, the block itself and dpdg_decision_checker.
module density_peak_decision_graph_tb;
  import dpdg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ENTRIES = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POINT_COUNT;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [15:0]          in_pair_distance = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [5:0]           out_point_index;
  logic [6:0]           out_local_density;
  logic [15:0]          out_dependent_distance;
  logic                 out_has_denser;
  logic [5:0]           out_denser_neighbor;
  logic [21:0]          out_peak_score;
  logic                 out_last_result;

  int fail_count;
  int pending_count;
  int checked_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;
  int cycles = 0;
  int matrices = 0;
  int entries = 0;
  int points_now = 64;
  logic [15:0] radius_now = 16'(CUTOFF_RESET);
  logic [15:0] triangle [9] = '{16'h0000, 16'h0080, 16'h0300,
                                16'h0080, 16'h0000, 16'h0080,
                                16'h0300, 16'h0080, 16'h0000};

  density_peak_decision_graph uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_pair_distance(in_pair_distance),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_index(out_point_index), .out_local_density(out_local_density),
    .out_dependent_distance(out_dependent_distance), .out_has_denser(out_has_denser),
    .out_denser_neighbor(out_denser_neighbor), .out_peak_score(out_peak_score),
    .out_last_result(out_last_result)
  );

  dpdg_decision_checker decision_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_pair_distance(in_pair_distance),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_index(out_point_index), .out_local_density(out_local_density),
    .out_dependent_distance(out_dependent_distance), .out_has_denser(out_has_denser),
    .out_denser_neighbor(out_denser_neighbor), .out_peak_score(out_peak_score),
    .out_last_result(out_last_result),
    .fail_count(fail_count), .pending_count(pending_count), .checked_count(checked_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver either holds off for a counted stretch or stalls at random.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding", cycles,
               pending_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    int n;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_POINT_COUNT) begin
      n = val[6:0];
      points_now = (n < 1) ? 1 : (n > 64) ? 64 : n;
    end else if (idx == CFG_CUTOFF_RADIUS) begin
      radius_now = val;
    end
  endtask

  task automatic send_entry(input logic [15:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pair_distance <= d;
    do @(posedge clk); while (in_stall);
    entries++;
  endtask

  // Drops valid and waits until every predicted result has been transferred.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return radius_now + 16'($urandom_range(2)) - 16'd1;
      5, 6: return 16'($urandom_range(32'(radius_now) * 2 + 1 > 65535 ? 65535 :
                                      32'(radius_now) * 2 + 1));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(1024));
    endcase
  endfunction

  task automatic send_random_matrix();
    for (int k = 0; k < points_now * points_now; k++) send_entry(pick_distance());
    matrices++;
  endtask

  task automatic set_idling(input int phase);
    case (phase % 5)
      1: begin send_idle_pct = 72; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 72; end
      3: begin send_idle_pct = 37; recv_stall_pct = 37; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    int start_entries;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A point count code of zero runs a single point; the second case has its own
    // diagonal above the radius and so a density of zero.
    write_reg(CFG_POINT_COUNT, 16'h0080);
    write_reg(CFG_CUTOFF_RADIUS, 16'h0000);
    send_entry(16'h0000);
    settle();
    send_entry(16'hFFFF);
    settle();
    matrices += 2;

    write_reg(CFG_POINT_COUNT, 16'd3);
    write_reg(CFG_CUTOFF_RADIUS, 16'h0100);
    foreach (triangle[k]) send_entry(triangle[k]);
    settle();
    matrices++;

    // The point count grows part way through a load, and later shrinks.
    set_idling(3);
    write_reg(CFG_POINT_COUNT, 16'd2);
    send_entry(16'h0001);
    send_entry(16'h8000);
    settle();
    write_reg(CFG_POINT_COUNT, 16'd3);
    repeat (7) send_entry(pick_distance());
    settle();
    write_reg(CFG_POINT_COUNT, 16'd4);
    write_reg(CFG_SPARE_A, 16'h0001);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    repeat (3) send_entry(pick_distance());
    settle();
    write_reg(CFG_POINT_COUNT, 16'd2);
    send_entry(16'h7FFF);
    settle();
    matrices += 2;

    // An oversized point count code is held at the largest size until it shrinks mid-load.
    write_reg(CFG_POINT_COUNT, 16'hFFFF);
    write_reg(CFG_CUTOFF_RADIUS, 16'hFFFF);
    repeat (3) send_entry(pick_distance());
    settle();
    write_reg(CFG_POINT_COUNT, 16'd2);
    send_entry(16'hFFFF);
    settle();
    matrices++;

    start_entries = entries;
    while (entries - start_entries < RANDOM_ENTRIES) begin
      set_idling(matrices);
      write_reg(CFG_POINT_COUNT, 16'($urandom_range(1, 8)));
      write_reg(CFG_CUTOFF_RADIUS, pick_radius());
      if (matrices == 8) begin
        // The receiver holds off while a second matrix is offered behind the first.
        set_idling(0);
        write_reg(CFG_POINT_COUNT, 16'd6);
        stall_hold = HOLD_CYCLES;
        send_random_matrix();
      end
      send_random_matrix();
      settle();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d distance matrices (%0d entries) and %0d point decisions,", matrices,
             entries, checked_count);
    $display("with one to eight points, clamped and mid-load size changes and varied idling.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dpdg_pkg.sv
rtl/density_peak_decision_graph.sv
dv/dpdg_decision_checker.sv
dv/density_peak_decision_graph_tb.sv
